### design/tlwc_pkg.sv
// Shared types and constants for the two-level write-back cache tag block.
// No dependencies.
package tlwc_pkg;

	localparam int WAYS = 8;
	localparam int L1_SET_COUNT_D = 64;
	localparam int L2_SET_COUNT_D = 512;
	localparam int LINE_OFFSET_BITS_D = 6;
	localparam logic [31:0] RECENCY_INIT = 32'h7654_3210;
	localparam logic [31:0] COUNTER_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [63:0] address;
		logic        wr_access;
		logic        last_in_run;
	} req_t;

	typedef struct packed {
		logic        l1_hit;
		logic        l2_hit;
		logic [1:0]  writebacks;
		logic [31:0] reads_total;
		logic [31:0] writes_total;
		logic [31:0] l1_hits_total;
		logic [31:0] l1_misses_total;
		logic [31:0] l2_hits_total;
		logic [31:0] l2_misses_total;
		logic [31:0] writebacks_total;
	} rsp_t;

	// controller to datapath
	typedef enum logic [2:0] {
		OP_NONE,
		OP_L1_RD,   // read L1 and L2 sets
		OP_L1_EVAL, // L1 compare and L1 victim choice; state update on a hit
		OP_L2_EVAL, // L2 compare for the new line, then read victim set
		OP_V_EVAL,  // L2 compare for the written-back victim
		OP_FINISH   // fill L1 on a miss, emit result
	} op_t;

	typedef struct packed {
		op_t  op;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic l1_hit;
		logic need_wb; // L1 victim dirty, its line goes to L2
	} stat_t;

	// move a way to the front of a recency list
	function automatic logic [31:0] touch(input logic [31:0] list, input logic [2:0] way);
		logic [31:0] r;
		logic found;
		r = list;
		found = 1'b0;
		for (int p = 0; p < 8; p++) begin
			if (!found && list[4*p +: 4] == {1'b0, way}) begin
				found = 1'b1;
				for (int q = 1; q <= p; q++) r[4*q +: 4] = list[4*(q-1) +: 4];
				r[3:0] = {1'b0, way};
			end
		end
		return r;
	endfunction

	function automatic logic [2:0] victim(input logic [31:0] list, input logic [7:0] valid);
		logic [2:0] v;
		logic f;
		v = list[30:28];
		f = 1'b0;
		for (int w = 0; w < 8; w++) begin
			if (!f && !valid[w]) begin
				v = 3'(w);
				f = 1'b1;
			end
		end
		return v;
	endfunction

	function automatic logic [31:0] sat_inc(input logic [31:0] c, input logic en);
		return (en && c != COUNTER_MAX) ? c + 32'd1 : c;
	endfunction

	function automatic logic [31:0] sat_add(input logic [31:0] c, input logic [1:0] n);
		logic [32:0] s;
		s = {1'b0, c} + {31'b0, n};
		return s[32] ? COUNTER_MAX : s[31:0];
	endfunction

endpackage

### design/tlwc_ctrl.sv
// Sequencer for the cache tag block: steps each access through its phases.
// Depends on tlwc_pkg.
module tlwc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            ready,
	input  tlwc_pkg::stat_t stat,
	output logic            busy,
	output tlwc_pkg::cmd_t  cmd
);
	typedef enum logic [2:0] {S_IDLE, S_L1RD, S_L1EV, S_L2EV, S_VEV, S_FIN} state_t;
	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (start && ready) state_q <= S_L1RD;
				S_L1RD: state_q <= S_L1EV;
				S_L1EV: state_q <= stat.l1_hit ? S_FIN : S_L2EV;
				S_L2EV: state_q <= stat.need_wb ? S_VEV : S_FIN;
				S_VEV:  state_q <= S_FIN;
				S_FIN:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE) || !ready;

	always_comb begin
		cmd.load = (state_q == S_IDLE) && start && ready;
		unique case (state_q)
			S_L1RD:  cmd.op = tlwc_pkg::OP_L1_RD;
			S_L1EV:  cmd.op = tlwc_pkg::OP_L1_EVAL;
			S_L2EV:  cmd.op = tlwc_pkg::OP_L2_EVAL;
			S_VEV:   cmd.op = tlwc_pkg::OP_V_EVAL;
			S_FIN:   cmd.op = tlwc_pkg::OP_FINISH;
			default: cmd.op = tlwc_pkg::OP_NONE;
		endcase
	end

`ifndef SYNTHESIS
	a_fin_one: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN |=> state_q == S_IDLE) else $error("finish not single");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !cmd.load) else $error("load while busy");
	a_l1rd_next: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_L1RD |=> state_q == S_L1EV) else $error("bad sequence");
`endif
endmodule

### design/tlwc_dp.sv
// Datapath: tag memories, per-set valid/dirty/recency memories, counters.
// Depends on tlwc_pkg.
module tlwc_dp #(
	parameter int L1_SET_COUNT = tlwc_pkg::L1_SET_COUNT_D,
	parameter int L2_SET_COUNT = tlwc_pkg::L2_SET_COUNT_D,
	parameter int LINE_OFFSET_BITS = tlwc_pkg::LINE_OFFSET_BITS_D
) (
	input  logic            clk,
	input  logic            arst_n,
	input  tlwc_pkg::req_t  req,
	input  tlwc_pkg::cmd_t  cmd,
	output tlwc_pkg::stat_t stat,
	output logic            ready,
	output logic            done,
	output tlwc_pkg::rsp_t  rsp
);
	localparam int S1B = $clog2(L1_SET_COUNT);
	localparam int S2B = $clog2(L2_SET_COUNT);
	localparam int LB = 64 - LINE_OFFSET_BITS;
	localparam int T1B = LB - S1B;
	localparam int T2B = LB - S2B;
	localparam int CB = (S1B > S2B ? S1B : S2B) + 1;

	// tag arrays: one word per set holding all ways
	logic [8*T1B-1:0] l1_tag_mem [L1_SET_COUNT];
	logic [8*T2B-1:0] l2_tag_mem [L2_SET_COUNT];
	// state: {recency, dirty, valid}
	logic [47:0] l1_st_mem [L1_SET_COUNT];
	logic [47:0] l2_st_mem [L2_SET_COUNT];

	logic [CB-1:0] clr_q;
	logic clearing_q;

	logic [LB-1:0] line_q;
	logic wr_q, last_q;
	logic [8*T1B-1:0] l1t_q;
	logic [47:0] l1s_q;
	logic [8*T2B-1:0] l2t_q;
	logic [47:0] l2s_q;
	logic [2:0] v1_q;
	logic [LB-1:0] vline_q;
	logic l1h_q, l2h_q, l2m_q;
	logic [1:0] wbs_q;
	logic [31:0] cnt_q [7];

	logic [S1B-1:0] s1;
	logic [T1B-1:0] t1;
	logic [S2B-1:0] s2, sv;
	logic [T2B-1:0] t2, tv;
	assign s1 = line_q[S1B-1:0];
	assign t1 = line_q[LB-1:S1B];
	assign s2 = line_q[S2B-1:0];
	assign t2 = line_q[LB-1:S2B];
	assign sv = vline_q[S2B-1:0];
	assign tv = vline_q[LB-1:S2B];

	logic [7:0] h1, h2, hv;
	logic [2:0] w1, w2, wv, vic1, vic2, vicv;
	logic [7:0] l1v, l1d, l2v, l2d;
	logic [31:0] l1r, l2r;
	assign {l1r, l1d, l1v} = l1s_q;
	assign {l2r, l2d, l2v} = l2s_q;

	always_comb begin
		w1 = '0;
		w2 = '0;
		wv = '0;
		for (int w = 0; w < 8; w++) begin
			h1[w] = l1v[w] && l1t_q[w*T1B +: T1B] == t1;
			h2[w] = l2v[w] && l2t_q[w*T2B +: T2B] == t2;
			hv[w] = l2v[w] && l2t_q[w*T2B +: T2B] == tv;
		end
		for (int w = 7; w >= 0; w--) begin
			if (h1[w]) w1 = 3'(w);
			if (h2[w]) w2 = 3'(w);
			if (hv[w]) wv = 3'(w);
		end
		vic1 = tlwc_pkg::victim(l1r, l1v);
		vic2 = tlwc_pkg::victim(l2r, l2v);
		vicv = vic2;
	end

	assign stat.l1_hit = |h1;
	assign stat.need_wb = l1v[v1_q] && l1d[v1_q];
	assign ready = !clearing_q;

	logic [8*T1B-1:0] l1t_new;
	logic [8*T2B-1:0] l2t_new;
	always_comb begin
		l1t_new = l1t_q;
		l1t_new[v1_q*T1B +: T1B] = t1;
		l2t_new = l2t_q;
		if (cmd.op == tlwc_pkg::OP_L2_EVAL) l2t_new[vic2*T2B +: T2B] = t2;
		else l2t_new[vicv*T2B +: T2B] = tv;
	end

	// memories
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			if (clr_q < CB'(L1_SET_COUNT))
				l1_st_mem[clr_q[S1B-1:0]] <= {tlwc_pkg::RECENCY_INIT, 16'h0};
			if (clr_q < CB'(L2_SET_COUNT))
				l2_st_mem[clr_q[S2B-1:0]] <= {tlwc_pkg::RECENCY_INIT, 16'h0};
		end else begin
			case (cmd.op)
				tlwc_pkg::OP_L1_RD: begin
					l1t_q <= l1_tag_mem[s1];
					l1s_q <= l1_st_mem[s1];
					l2t_q <= l2_tag_mem[s2];
					l2s_q <= l2_st_mem[s2];
				end
				tlwc_pkg::OP_L1_EVAL: begin
					v1_q <= vic1;
					vline_q <= LB'({l1t_q[vic1*T1B +: T1B], s1});
					if (|h1)
						l1_st_mem[s1] <= {tlwc_pkg::touch(l1r, w1), l1d | ({7'b0, wr_q} << w1), l1v};
				end
				tlwc_pkg::OP_L2_EVAL: begin
					if (|h2) begin
						l2_st_mem[s2] <= {tlwc_pkg::touch(l2r, w2), l2d, l2v};
					end else begin
						l2_st_mem[s2] <= {tlwc_pkg::touch(l2r, vic2), l2d & ~(8'h1 << vic2),
							l2v | (8'h1 << vic2)};
						l2_tag_mem[s2] <= l2t_new;
					end
				end
				tlwc_pkg::OP_V_EVAL: begin
					if (|hv) begin
						l2_st_mem[sv] <= {l2r, l2d | (8'h1 << wv), l2v};
					end else begin
						l2_st_mem[sv] <= {tlwc_pkg::touch(l2r, vicv), l2d | (8'h1 << vicv),
							l2v | (8'h1 << vicv)};
						l2_tag_mem[sv] <= l2t_new;
					end
				end
				tlwc_pkg::OP_FINISH: if (!l1h_q) begin
					l1_tag_mem[s1] <= l1t_new;
					l1_st_mem[s1] <= {tlwc_pkg::touch(l1r, v1_q),
						(l1d & ~(8'h1 << v1_q)) | ({7'b0, wr_q} << v1_q),
						l1v | (8'h1 << v1_q)};
				end
				default: ;
			endcase
			// victim set read after the new-line L2 update; the same set takes the new words
			if (cmd.op == tlwc_pkg::OP_L2_EVAL) begin
				if (sv == s2) begin
					if (|h2) begin
						l2s_q <= {tlwc_pkg::touch(l2r, w2), l2d, l2v};
					end else begin
						l2s_q <= {tlwc_pkg::touch(l2r, vic2), l2d & ~(8'h1 << vic2),
							l2v | (8'h1 << vic2)};
						l2t_q <= l2t_new;
					end
				end else begin
					l2t_q <= l2_tag_mem[sv];
					l2s_q <= l2_st_mem[sv];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q <= '0;
			done <= 1'b0;
			for (int k = 0; k < 7; k++) cnt_q[k] <= '0;
			l1h_q <= 1'b0;
			l2h_q <= 1'b0;
			l2m_q <= 1'b0;
			wbs_q <= '0;
		end else begin
			done <= 1'b0;
			if (clearing_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == CB'(L2_SET_COUNT > L1_SET_COUNT ? L2_SET_COUNT - 1 : L1_SET_COUNT - 1))
					clearing_q <= 1'b0;
			end
			if (cmd.load) begin
				l1h_q <= 1'b0;
				l2h_q <= 1'b0;
				l2m_q <= 1'b0;
				wbs_q <= '0;
			end
			case (cmd.op)
				tlwc_pkg::OP_L1_EVAL: l1h_q <= |h1;
				tlwc_pkg::OP_L2_EVAL: begin
					l2h_q <= |h2;
					l2m_q <= !(|h2);
					if (!(|h2) && l2v[vic2] && l2d[vic2]) wbs_q <= wbs_q + 2'd1;
				end
				tlwc_pkg::OP_V_EVAL:
					if (!(|hv) && l2v[vicv] && l2d[vicv]) wbs_q <= wbs_q + 2'd1;
				tlwc_pkg::OP_FINISH: begin
					done <= 1'b1;
					cnt_q[0] <= last_q ? '0 : tlwc_pkg::sat_inc(cnt_q[0], !wr_q);
					cnt_q[1] <= last_q ? '0 : tlwc_pkg::sat_inc(cnt_q[1], wr_q);
					cnt_q[2] <= last_q ? '0 : tlwc_pkg::sat_inc(cnt_q[2], l1h_q);
					cnt_q[3] <= last_q ? '0 : tlwc_pkg::sat_inc(cnt_q[3], !l1h_q);
					cnt_q[4] <= last_q ? '0 : tlwc_pkg::sat_inc(cnt_q[4], l2h_q);
					cnt_q[5] <= last_q ? '0 : tlwc_pkg::sat_inc(cnt_q[5], l2m_q);
					cnt_q[6] <= last_q ? '0 : tlwc_pkg::sat_add(cnt_q[6], wbs_q);
					rsp.l1_hit <= l1h_q;
					rsp.l2_hit <= l2h_q;
					rsp.writebacks <= wbs_q;
					rsp.reads_total <= tlwc_pkg::sat_inc(cnt_q[0], !wr_q);
					rsp.writes_total <= tlwc_pkg::sat_inc(cnt_q[1], wr_q);
					rsp.l1_hits_total <= tlwc_pkg::sat_inc(cnt_q[2], l1h_q);
					rsp.l1_misses_total <= tlwc_pkg::sat_inc(cnt_q[3], !l1h_q);
					rsp.l2_hits_total <= tlwc_pkg::sat_inc(cnt_q[4], l2h_q);
					rsp.l2_misses_total <= tlwc_pkg::sat_inc(cnt_q[5], l2m_q);
					rsp.writebacks_total <= tlwc_pkg::sat_add(cnt_q[6], wbs_q);
				end
				default: ;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			line_q <= req.address[63:LINE_OFFSET_BITS];
			wr_q <= req.wr_access;
			last_q <= req.last_in_run;
		end
	end

`ifndef SYNTHESIS
	a_wbs: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.writebacks != 2'd3) else $error("too many writebacks");
	a_hit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(rsp.l1_hit && rsp.l2_hit)) else $error("both hits");
	a_noload_clr: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !cmd.load) else $error("load while clearing");
`endif
endmodule

### design/two_level_writeback_cache_tags.sv
// Two-level write-back cache tag block: top level.
// Depends on tlwc_pkg, tlwc_ctrl, tlwc_dp.
//
// Usage: drive req and raise start; the access is taken at an edge where
// start is high and busy is low. One result appears on rsp for a single
// cycle, flagged by done; the receiver cannot stall it.
// Phases: an L1 hit goes through L1 read, L1 compare and finish; a miss adds
// the L2 compare, and a miss with a dirty L1 victim also the victim compare;
// busy covers this span, set by the single-port set memories visited in turn.
// Reset: valid, dirty and recency words are swept, one set per cycle, over
// max(L1_SET_COUNT, L2_SET_COUNT) sets (512 by default) while busy is high;
// run totals clear at once. Tag words are not cleared.
// Run totals include the current transaction and clear after a transaction
// flagged last_in_run.
module two_level_writeback_cache_tags #(
	parameter int L1_SET_COUNT = tlwc_pkg::L1_SET_COUNT_D,
	parameter int L2_SET_COUNT = tlwc_pkg::L2_SET_COUNT_D,
	parameter int LINE_OFFSET_BITS = tlwc_pkg::LINE_OFFSET_BITS_D
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  tlwc_pkg::req_t req,
	output logic           busy,
	output logic           done,
	output tlwc_pkg::rsp_t rsp
);
	tlwc_pkg::cmd_t  cmd;
	tlwc_pkg::stat_t stat;
	logic ready;

	tlwc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .ready(ready),
		.stat(stat), .busy(busy), .cmd(cmd)
	);

	tlwc_dp #(
		.L1_SET_COUNT(L1_SET_COUNT), .L2_SET_COUNT(L2_SET_COUNT),
		.LINE_OFFSET_BITS(LINE_OFFSET_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .cmd(cmd), .stat(stat),
		.ready(ready), .done(done), .rsp(rsp)
	);
endmodule
